// ===== rtl/core/assert_macros.svh =====
// assertion macros for the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, muted while reset is high
`define ASSERT_CLK(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("assertion failed");

// clocked assertion, also checked during reset
`define ASSERT_CLK_ALWAYS(label, clk, prop) \
   label: assert property (@(posedge clk) prop) \
      else $error("assertion failed");

`endif

// ===== rtl/core/mpe_pkg.sv =====
// ----------------------------------------------------------------------------
// mpe_pkg
// types, constants and saturating helpers for the escape-tree leaf counter
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package mpe_pkg;

   localparam int TREE_DEPTH_DEF = 16;
   localparam int QBITS          = 28;
   localparam int COUNT_W        = 18;

   localparam logic signed [31:0] BEND_A_X_RST  = 32'sd189812532;
   localparam logic signed [31:0] BEND_A_Y_RST  = 32'sd189812532;
   localparam logic signed [31:0] BEND_B_X_RST  = -32'sd189812532;
   localparam logic signed [31:0] BEND_B_Y_RST  = 32'sd189812532;
   localparam logic signed [31:0] SHIFT_X_RST   = 32'sd0;
   localparam logic signed [31:0] SHIFT_Y_RST   = -32'sd40265318;
   localparam logic signed [31:0] ZOOM_RST      = 32'sd536870912;
   localparam logic [30:0]        LIMIT_RST     = 31'd1073741824;
   localparam logic [30:0]        RATIO_SAT     = 31'h7FFF_FFFF;

   // register index map
   typedef enum logic [2:0] {
      CSR_BEND_A_X, CSR_BEND_A_Y, CSR_BEND_B_X, CSR_BEND_B_Y,
      CSR_SHIFT_X, CSR_SHIFT_Y, CSR_ZOOM_SCALE, CSR_ESCAPE_LIMIT
   } csr_index_type;

   // map unit sequencer
   typedef enum logic [4:0] {
      MU_IDLE, MU_DIFF, MU_SQ_DX, MU_SQ_DY, MU_SQ_BX, MU_SQ_BY, MU_RANGE,
      MU_SAT, MU_DIVIDE, MU_MUL_DX, MU_MUL_DY, MU_REFLECT, MU_ZOOM_X,
      MU_ZOOM_Y, MU_MAG_X, MU_MAG_Y, MU_CHECK
   } map_state_type;

   // tree walk sequencer
   typedef enum logic [2:0] {
      TW_IDLE, TW_START, TW_WAIT, TW_ADVANCE, TW_DONE
   } walk_state_type;

   // map unit status toward the walker
   typedef struct packed {
      logic done;
      logic ok;
   } map_status_type;

   // clamp a 33-bit sum to the signed 32-bit range
   function automatic logic signed [31:0] sat33(input logic signed [32:0] v);
      logic signed [31:0] r;
      if (v[32] != v[31]) r = v[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
      else r = v[31:0];
      return r;
   endfunction

   function automatic logic signed [31:0] add_sat(input logic signed [31:0] a,
                                                  input logic signed [31:0] b);
      logic signed [32:0] s;
      s = {a[31], a} + {b[31], b};
      return sat33(s);
   endfunction

   function automatic logic signed [31:0] neg_sat(input logic signed [31:0] a);
      logic signed [32:0] s;
      s = 33'sd0 - {a[31], a};
      return sat33(s);
   endfunction

   // Q4.28 product rescale: arithmetic shift is floor, then clamp
   function automatic logic signed [31:0] scale_sat(input logic signed [63:0] p);
      logic signed [35:0] s;
      logic signed [31:0] r;
      s = p[63:QBITS];
      if (s[35:31] == 5'b00000 || s[35:31] == 5'b11111) r = s[31:0];
      else r = s[35] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
      return r;
   endfunction

endpackage

// ===== rtl/core/mpe_map_unit.sv =====
// ----------------------------------------------------------------------------
// mpe_map_unit
// evaluates one map on one point with a shared multiplier and a
// bit-serial restoring divider, reports escape or the new point
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mpe_map_unit import mpe_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic signed [31:0] point_x,
   input  logic signed [31:0] point_y,
   input  logic signed [31:0] bend_x,
   input  logic signed [31:0] bend_y,
   input  logic signed [31:0] shift_x,
   input  logic signed [31:0] shift_y,
   input  logic signed [31:0] zoom_scale,
   input  logic signed [31:0] offset_x,
   input  logic signed [31:0] offset_y,
   input  logic [30:0]        escape_limit,
   output map_status_type     status,
   output logic signed [31:0] new_x,
   output logic signed [31:0] new_y
);

   map_state_type state_ff, state_in;

   logic signed [31:0] dx_ff, dx_in, dy_ff, dy_in;
   logic signed [31:0] x_ff, x_in, y_ff, y_in;
   logic signed [63:0] prod_ff, prod_in;
   logic [63:0]        r2_ff, r2_in;
   logic [67:0]        rem_ff, rem_in;
   logic [30:0]        q_ff, q_in;
   logic [4:0]         cnt_ff, cnt_in;

   logic signed [31:0] mul_a, mul_b;
   logic [67:0]        div_d;
   logic [63:0]        mag;
   logic               zero_r, ratio_big, escaped;

   // shared multiplier
   assign prod_in = mul_a * mul_b;

   assign div_d     = {2'b00, r2_ff, 2'b00};
   assign zero_r    = (r2_ff == 64'd0);
   assign ratio_big = (rem_ff >= {1'b0, r2_ff, 3'b000});
   assign mag       = r2_ff + $unsigned(prod_ff);
   assign escaped   = (mag > {5'd0, escape_limit, 28'd0});

   assign new_x = x_ff;
   assign new_y = y_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         MU_IDLE:    if (start) state_in = MU_DIFF;
         MU_DIFF:    state_in = MU_SQ_DX;
         MU_SQ_DX:   state_in = MU_SQ_DY;
         MU_SQ_DY:   state_in = MU_SQ_BX;
         MU_SQ_BX:   state_in = MU_SQ_BY;
         MU_SQ_BY:   state_in = MU_RANGE;
         MU_RANGE:   state_in = zero_r ? MU_IDLE : MU_SAT;
         MU_SAT:     state_in = ratio_big ? MU_MUL_DX : MU_DIVIDE;
         MU_DIVIDE:  if (cnt_ff == 5'd30) state_in = MU_MUL_DX;
         MU_MUL_DX:  state_in = MU_MUL_DY;
         MU_MUL_DY:  state_in = MU_REFLECT;
         MU_REFLECT: state_in = MU_ZOOM_X;
         MU_ZOOM_X:  state_in = MU_ZOOM_Y;
         MU_ZOOM_Y:  state_in = MU_MAG_X;
         MU_MAG_X:   state_in = MU_MAG_Y;
         MU_MAG_Y:   state_in = MU_CHECK;
         MU_CHECK:   state_in = MU_IDLE;
      endcase
   end

   // datapath and status per step
   always_comb begin
      mul_a  = dx_ff;
      mul_b  = dx_ff;
      dx_in  = dx_ff;
      dy_in  = dy_ff;
      x_in   = x_ff;
      y_in   = y_ff;
      r2_in  = r2_ff;
      rem_in = rem_ff;
      q_in   = q_ff;
      cnt_in = cnt_ff;
      status = '0;
      unique case (state_ff)
         MU_IDLE: ;
         MU_DIFF: begin
            dy_in = sat33({point_y[31], point_y} - {bend_y[31], bend_y});
            dx_in = sat33({point_x[31], point_x} - {bend_x[31], bend_x});
         end
         MU_SQ_DX: ;
         MU_SQ_DY: begin
            r2_in = $unsigned(prod_ff);
            mul_a = dy_ff;
            mul_b = dy_ff;
         end
         MU_SQ_BX: begin
            r2_in = r2_ff + $unsigned(prod_ff);
            mul_a = bend_x;
            mul_b = bend_x;
         end
         MU_SQ_BY: begin
            rem_in = {4'd0, $unsigned(prod_ff)};
            mul_a  = bend_y;
            mul_b  = bend_y;
         end
         MU_RANGE: begin
            rem_in = rem_ff + {4'd0, $unsigned(prod_ff)};
            if (zero_r) status = '{done: 1'b1, ok: 1'b0};
         end
         MU_SAT: begin
            cnt_in = 5'd0;
            if (ratio_big) q_in = RATIO_SAT;
         end
         // one quotient bit a cycle, integer bits first
         MU_DIVIDE: begin
            cnt_in = cnt_ff + 5'd1;
            if (rem_ff >= div_d) begin
               rem_in = {rem_ff - div_d} << 1;
               q_in   = {q_ff[29:0], 1'b1};
            end else begin
               rem_in = rem_ff << 1;
               q_in   = {q_ff[29:0], 1'b0};
            end
         end
         MU_MUL_DX: begin
            mul_a = dx_ff;
            mul_b = {1'b0, q_ff};
         end
         MU_MUL_DY: begin
            x_in  = add_sat(scale_sat(prod_ff), bend_x);
            mul_a = dy_ff;
            mul_b = {1'b0, q_ff};
         end
         MU_REFLECT: begin
            y_in = add_sat(scale_sat(prod_ff), bend_y);
            x_in = add_sat(neg_sat(x_ff), shift_x);
         end
         MU_ZOOM_X: begin
            y_in  = add_sat(y_ff, shift_y);
            mul_a = x_ff;
            mul_b = zoom_scale;
         end
         MU_ZOOM_Y: begin
            x_in  = add_sat(scale_sat(prod_ff), offset_x);
            mul_a = y_ff;
            mul_b = zoom_scale;
         end
         MU_MAG_X: begin
            y_in  = add_sat(scale_sat(prod_ff), offset_y);
            mul_a = x_ff;
            mul_b = x_ff;
         end
         MU_MAG_Y: begin
            r2_in = $unsigned(prod_ff);
            mul_a = y_ff;
            mul_b = y_ff;
         end
         MU_CHECK: status = '{done: 1'b1, ok: !escaped};
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= MU_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      dx_ff   <= dx_in;
      dy_ff   <= dy_in;
      x_ff    <= x_in;
      y_ff    <= y_in;
      prod_ff <= prod_in;
      r2_ff   <= r2_in;
      rem_ff  <= rem_in;
      q_ff    <= q_in;
   end

endmodule

// ===== rtl/core/mobius_pair_escape_leaf_count.sv =====
// ----------------------------------------------------------------------------
// mobius_pair_escape_leaf_count
// depth-first walk of a binary tree of map pairs, counting surviving leaves
// ----------------------------------------------------------------------------
// one map evaluation runs the bit-serial divider, which is skipped when the inversion
// ratio saturates; a zero radius ends the evaluation early as an escape
// item flow: accept, the evaluations, an advance step per switch to map B or
// backtrack step, then the result; worst case 2^(TREE_DEPTH+2)-2 evaluations,
// one item in flight at a time
// synchronous active-high reset restores register defaults and goes idle
`timescale 1ns / 1ps

module mobius_pair_escape_leaf_count import mpe_pkg::*; #(
   parameter int TREE_DEPTH = TREE_DEPTH_DEF
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // start_x, start_y, offset_x, offset_y
   input  logic [127:0] req_tdata,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // leaf_count, zero padding
   output logic [23:0]  rsp_tdata,
   input  logic         csr_we,
   input  logic [2:0]   csr_addr,
   input  logic [31:0]  csr_wdata
);

   localparam int LEVELS = TREE_DEPTH + 1;
   localparam int LVL_W  = (LEVELS > 1) ? $clog2(LEVELS) : 1;

   // configuration registers
   logic signed [31:0] bend_a_x_ff, bend_a_y_ff, bend_b_x_ff, bend_b_y_ff;
   logic signed [31:0] shift_x_ff, shift_y_ff, zoom_ff;
   logic [30:0]        limit_ff;
   logic signed [31:0] off_x_ff, off_y_ff;

   walk_state_type     state_ff, state_in;
   logic [LVL_W-1:0]   lvl_ff, lvl_in;
   logic [COUNT_W-1:0] count_ff, count_in;

   // point stack, one entry per level, plus which map is in progress
   logic signed [31:0] px_ff [LEVELS];
   logic signed [31:0] py_ff [LEVELS];
   logic [LEVELS-1:0]  sel_ff;

   logic               stk_we, sel_set;
   logic [LVL_W-1:0]   stk_idx;
   logic signed [31:0] stk_x, stk_y;
   logic               unit_start;
   map_status_type     unit_status;
   logic signed [31:0] unit_x, unit_y;
   logic               at_leaf, accept;

   assign accept  = req_tvalid && req_tready;
   assign at_leaf = (lvl_ff == LVL_W'(TREE_DEPTH));

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         bend_a_x_ff <= BEND_A_X_RST;
         bend_a_y_ff <= BEND_A_Y_RST;
         bend_b_x_ff <= BEND_B_X_RST;
         bend_b_y_ff <= BEND_B_Y_RST;
         shift_x_ff  <= SHIFT_X_RST;
         shift_y_ff  <= SHIFT_Y_RST;
         zoom_ff     <= ZOOM_RST;
         limit_ff    <= LIMIT_RST;
      end else if (csr_we) begin
         unique case (csr_index_type'(csr_addr))
            CSR_BEND_A_X:     bend_a_x_ff <= csr_wdata;
            CSR_BEND_A_Y:     bend_a_y_ff <= csr_wdata;
            CSR_BEND_B_X:     bend_b_x_ff <= csr_wdata;
            CSR_BEND_B_Y:     bend_b_y_ff <= csr_wdata;
            CSR_SHIFT_X:      shift_x_ff  <= csr_wdata;
            CSR_SHIFT_Y:      shift_y_ff  <= csr_wdata;
            CSR_ZOOM_SCALE:   zoom_ff     <= csr_wdata;
            CSR_ESCAPE_LIMIT: limit_ff    <= csr_wdata[30:0];
         endcase
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         TW_IDLE:  if (accept) state_in = TW_START;
         TW_START: state_in = TW_WAIT;
         TW_WAIT: begin
            if (unit_status.done) begin
               if (unit_status.ok && !at_leaf) state_in = TW_START;
               else state_in = TW_ADVANCE;
            end
         end
         TW_ADVANCE: begin
            if (!sel_ff[lvl_ff]) state_in = TW_START;
            else if (lvl_ff == '0) state_in = TW_DONE;
         end
         TW_DONE:  if (rsp_tready) state_in = TW_IDLE;
      endcase
   end

   // walk control and stack updates
   always_comb begin
      req_tready = 1'b0;
      rsp_tvalid = 1'b0;
      unit_start = 1'b0;
      stk_we     = 1'b0;
      sel_set    = 1'b0;
      stk_idx    = lvl_ff;
      stk_x      = unit_x;
      stk_y      = unit_y;
      lvl_in     = lvl_ff;
      count_in   = count_ff;
      unique case (state_ff)
         TW_IDLE: begin
            req_tready = 1'b1;
            if (accept) begin
               stk_we   = 1'b1;
               stk_idx  = '0;
               stk_x    = req_tdata[31:0];
               stk_y    = req_tdata[63:32];
               lvl_in   = '0;
               count_in = '0;
            end
         end
         TW_START: unit_start = 1'b1;
         TW_WAIT: begin
            if (unit_status.done && unit_status.ok) begin
               if (at_leaf) begin
                  if (count_ff != '1) count_in = count_ff + 1'b1;
               end else begin
                  stk_we  = 1'b1;
                  stk_idx = lvl_ff + 1'b1;
                  lvl_in  = lvl_ff + 1'b1;
               end
            end
         end
         TW_ADVANCE: begin
            if (!sel_ff[lvl_ff]) sel_set = 1'b1;
            else if (lvl_ff != '0) lvl_in = lvl_ff - 1'b1;
         end
         TW_DONE: rsp_tvalid = 1'b1;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= TW_IDLE;
         lvl_ff   <= '0;
         count_ff <= '0;
         sel_ff   <= '0;
      end else begin
         state_ff <= state_in;
         lvl_ff   <= lvl_in;
         count_ff <= count_in;
         if (stk_we) sel_ff[stk_idx] <= 1'b0;
         if (sel_set) sel_ff[lvl_ff] <= 1'b1;
      end
   end

   // stack and offset payload
   always_ff @(posedge clock) begin
      if (stk_we) begin
         px_ff[stk_idx] <= stk_x;
         py_ff[stk_idx] <= stk_y;
      end
      if (accept) begin
         off_x_ff <= req_tdata[95:64];
         off_y_ff <= req_tdata[127:96];
      end
   end

   mpe_map_unit u_map (
      .clock        (clock),
      .reset        (reset),
      .start        (unit_start),
      .point_x      (px_ff[lvl_ff]),
      .point_y      (py_ff[lvl_ff]),
      .bend_x       (sel_ff[lvl_ff] ? bend_b_x_ff : bend_a_x_ff),
      .bend_y       (sel_ff[lvl_ff] ? bend_b_y_ff : bend_a_y_ff),
      .shift_x      (shift_x_ff),
      .shift_y      (shift_y_ff),
      .zoom_scale   (zoom_ff),
      .offset_x     (off_x_ff),
      .offset_y     (off_y_ff),
      .escape_limit (limit_ff),
      .status       (unit_status),
      .new_x        (unit_x),
      .new_y        (unit_y)
   );

   assign rsp_tdata = {6'd0, count_ff};

endmodule

// ===== rtl/core/mpe_checker.sv =====
// ----------------------------------------------------------------------------
// mpe_checker
// port-level checks on the leaf counter, bound to the top level
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module mpe_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [23:0] rsp_tdata
);

   // one item at a time: never open for input while a result is shown
   `ASSERT_CLK(a_no_overlap, clock, reset, !(req_tready && rsp_tvalid))

   // an accepted transaction is never answered in the next cycle
   `ASSERT_CLK(a_no_instant_rsp, clock, reset, (req_tvalid && req_tready) |=> !rsp_tvalid)

   // padding above the count stays zero
   `ASSERT_CLK(a_pad_zero, clock, reset, rsp_tvalid |-> (rsp_tdata[23:18] == 6'd0))

   // a stalled result holds
   `ASSERT_CLK(a_rsp_hold, clock, reset, (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata)))

endmodule

bind mobius_pair_escape_leaf_count mpe_checker u_mpe_checker (.*);

// ===== bench/tb_mobius_pair_escape_leaf_count.sv =====
// ----------------------------------------------------------------------------
// tb_mobius_pair_escape_leaf_count
// self-checking bench for the escape-tree leaf counter: a behavioral
// predictor of the map pair walk computes each expected leaf count, and
// directed, register-sweep, backpressure and pause-resume tests drive the stream
// ports under several idle and stall patterns
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_mobius_pair_escape_leaf_count import mpe_pkg::*; ();

   localparam int HALF_PERIOD  = 6;
   localparam int WATCH_LIMIT  = 100000;
   localparam int EVAL_BUDGET  = 300;    // map evaluations allowed per transaction
   localparam int SETTLE       = 200;

   typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_type;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [127:0] req_tdata = '0;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [23:0]  rsp_tdata;
   logic         csr_we = 1'b0;
   logic [2:0]   csr_addr = '0;
   logic [31:0]  csr_wdata = '0;

   // predictor copy of the registers and the per-item offset
   int          bend_x [2];
   int          bend_y [2];
   int          shift_x, shift_y, zoom;
   longint      limit_q56;
   int          off_x, off_y;
   int unsigned leaves;
   int          evals;

   int unsigned   count_q[$];
   idle_mode_type idle_mode = IDLE_NONE;
   int unsigned   cycle_no = 0;
   int unsigned   hold_until = 0;
   int unsigned   quiet_cycles = 0;
   int            errors = 0;

   mobius_pair_escape_leaf_count dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .csr_we(csr_we), .csr_addr(csr_addr), .csr_wdata(csr_wdata)
   );

   always #(HALF_PERIOD) clock = ~clock;

   // ---------------- predictor ----------------

   function automatic int clamp32(input longint v);
      if (v > 64'sd2147483647) return 32'sh7FFF_FFFF;
      if (v < -64'sd2147483648) return 32'sh8000_0000;
      return int'(v);
   endfunction

   // Q4.28 product, floor, clamped
   function automatic int mul_q28(input int a, input int b);
      longint p;
      p = longint'(a) * longint'(b);
      return clamp32(p >>> QBITS);
   endfunction

   function automatic longint unsigned square(input int v);
      longint unsigned u;
      u = (v < 0) ? longint'(-longint'(v)) : longint'(v);
      return u * u;
   endfunction

   // one map step, returns 0 when the branch escapes
   function automatic bit map_step(input int m, input int px, input int py,
                                   output int nx, output int ny);
      int dx, dy, x, y;
      longint unsigned r2, b2, q, rem;
      nx = 0;
      ny = 0;
      dx = clamp32(longint'(px) - bend_x[m]);
      dy = clamp32(longint'(py) - bend_y[m]);
      r2 = square(dx) + square(dy);
      b2 = square(bend_x[m]) + square(bend_y[m]);
      // zero radius counts as escaped
      if (r2 == 0) return 1'b0;
      q = b2 / r2;
      if (q >= 8) begin
         q = 64'd2147483647;
      end else begin
         rem = b2 - q * r2;
         for (int i = 0; i < QBITS; i++) begin
            rem = rem << 1;
            q = q << 1;
            if (rem >= r2) begin
               rem = rem - r2;
               q = q | 64'd1;
            end
         end
      end
      x = clamp32(longint'(mul_q28(dx, int'(q))) + bend_x[m]);
      y = clamp32(longint'(mul_q28(dy, int'(q))) + bend_y[m]);
      x = clamp32(-longint'(x));
      x = clamp32(longint'(x) + shift_x);
      y = clamp32(longint'(y) + shift_y);
      x = mul_q28(x, zoom);
      y = mul_q28(y, zoom);
      x = clamp32(longint'(x) + off_x);
      y = clamp32(longint'(y) + off_y);
      if (square(x) + square(y) > longint'(limit_q56)) return 1'b0;
      nx = x;
      ny = y;
      return 1'b1;
   endfunction

   // depth-first descent, map A before map B; stops early past the budget
   function automatic void descend(input int px, input int py, input int levels);
      int nx, ny;
      for (int m = 0; m < 2; m++) begin
         if (evals > EVAL_BUDGET) return;
         evals++;
         if (map_step(m, px, py, nx, ny)) begin
            if (levels == 0) begin
               if (leaves < 262143) leaves++;
            end else begin
               descend(nx, ny, levels - 1);
            end
         end
      end
   endfunction

   // expected leaf count; returns 0 when the walk is too long for this run
   function automatic bit predict_leaves(input int sx, input int sy,
                                         input int ox, input int oy);
      off_x = ox;
      off_y = oy;
      leaves = 0;
      evals = 0;
      descend(sx, sy, TREE_DEPTH_DEF);
      return evals <= EVAL_BUDGET;
   endfunction

   // ---------------- drivers ----------------

   task automatic csr_write(input csr_index_type idx, input logic [31:0] value);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_addr <= idx;
      csr_wdata <= value;
      case (idx)
         CSR_BEND_A_X:     bend_x[0] = value;
         CSR_BEND_A_Y:     bend_y[0] = value;
         CSR_BEND_B_X:     bend_x[1] = value;
         CSR_BEND_B_Y:     bend_y[1] = value;
         CSR_SHIFT_X:      shift_x = value;
         CSR_SHIFT_Y:      shift_y = value;
         CSR_ZOOM_SCALE:   zoom = value;
         CSR_ESCAPE_LIMIT: limit_q56 = longint'(value[30:0]) << QBITS;
      endcase
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   // wait until every expected count has arrived, then let the block settle
   task automatic drain();
      wait (count_q.size() == 0);
      repeat (SETTLE) @(negedge clock);
   endtask

   // one transaction; skipped when the walk would exceed the budget
   task automatic send_point(input int sx, input int sy, input int ox, input int oy,
                             output bit sent);
      int gap;
      int pct;
      sent = predict_leaves(sx, sy, ox, oy);
      if (!sent) return;
      gap = 0;
      pct = (idle_mode == IDLE_SEND) ? 74 : (idle_mode == IDLE_BOTH) ? 7 : 0;
      while ($urandom_range(99) < pct) gap++;
      @(negedge clock);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {oy, ox, sy, sx};
      do @(posedge clock); while (!req_tready);
      count_q.push_back(leaves);
      // withdraw the accepted transaction so it is not taken twice
      @(negedge clock);
      req_tvalid <= 1'b0;
   endtask

   // random point: full-range noise or a near-origin point likely to live longer
   task automatic send_random();
      bit sent;
      int sx, sy, ox, oy;
      for (int tries = 0; tries < 40; tries++) begin
         if ($urandom_range(3) == 0) begin
            sx = $urandom; sy = $urandom; ox = $urandom; oy = $urandom;
         end else begin
            sx = $urandom_range(1073741823) - 536870912;
            sy = $urandom_range(1073741823) - 536870912;
            ox = $urandom_range(268435455) - 134217728;
            oy = $urandom_range(268435455) - 134217728;
         end
         send_point(sx, sy, ox, oy, sent);
         if (sent) return;
      end
      send_point($urandom, $urandom, 32'sh7FFF_FFFF, 32'sh8000_0000, sent);
   endtask

   task automatic send_many(input int n);
      for (int i = 0; i < n; i++) send_random();
   endtask

   task automatic load_defaults();
      csr_write(CSR_BEND_A_X, BEND_A_X_RST);
      csr_write(CSR_BEND_A_Y, BEND_A_Y_RST);
      csr_write(CSR_BEND_B_X, BEND_B_X_RST);
      csr_write(CSR_BEND_B_Y, BEND_B_Y_RST);
      csr_write(CSR_SHIFT_X, SHIFT_X_RST);
      csr_write(CSR_SHIFT_Y, SHIFT_Y_RST);
      csr_write(CSR_ZOOM_SCALE, ZOOM_RST);
      csr_write(CSR_ESCAPE_LIMIT, {1'b0, LIMIT_RST});
   endtask

   // ---------------- tests ----------------

   task automatic test_directed();
      bit sent;
      idle_mode = IDLE_NONE;
      // field extremes, zero and minus one
      send_point(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, sent);
      send_point(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, sent);
      send_point(32'sh7FFF_FFFF, 32'sh8000_0000, 0, 0, sent);
      send_point(0, 0, 32'sh8000_0000, 32'sh7FFF_FFFF, sent);
      send_point(0, 0, 0, 0, sent);
      send_point(-1, -1, -1, -1, sent);
      // start on a bend point: zero radius for that map
      send_point(BEND_A_X_RST, BEND_A_Y_RST, 0, 0, sent);
      send_point(BEND_B_X_RST, BEND_B_Y_RST, 32'sh1000_0000, 0, sent);
      // just off a bend point: the inversion ratio saturates
      send_point(BEND_A_X_RST + 1, BEND_A_Y_RST, 0, 0, sent);
      send_point(BEND_B_X_RST, BEND_B_Y_RST - 3, 0, 32'sh0100_0000, sent);
      drain();
      // zero zoom: every child lands on the offset; an offset on bend B
      // leaves only map A surviving below the first level
      csr_write(CSR_ZOOM_SCALE, 0);
      send_point(0, 0, BEND_B_X_RST, BEND_B_Y_RST, sent);
      send_point(0, 0, BEND_A_X_RST, BEND_A_Y_RST, sent);
      send_point(32'sh1000_0000, 0, 32'sh7000_0000, 0, sent);
      drain();
      // limit edge: offset magnitude exactly at the threshold survives
      csr_write(CSR_ESCAPE_LIMIT, 32'h1000_0000);
      send_point(0, 0, BEND_B_X_RST, 32'sh0, sent);
      send_point(0, 0, 32'sh1000_0000, 0, sent);
      send_point(0, 0, 32'sh1000_0001, 0, sent);
      drain();
      load_defaults();
   endtask

   task automatic test_config_sweep();
      // extremes first, then the defaults, then random settings, idle mode rotating per phase
      for (int phase = 0; phase < 8; phase++) begin
         idle_mode = idle_mode_type'(phase % 4);
         case (phase)
            0: begin
               csr_write(CSR_BEND_A_X, 32'h7FFF_FFFF); csr_write(CSR_BEND_A_Y, 32'h8000_0000);
               csr_write(CSR_BEND_B_X, 32'h8000_0000); csr_write(CSR_BEND_B_Y, 32'h7FFF_FFFF);
               csr_write(CSR_SHIFT_X, 32'h7FFF_FFFF);  csr_write(CSR_SHIFT_Y, 32'h8000_0000);
               csr_write(CSR_ZOOM_SCALE, 32'h7FFF_FFFF);
               csr_write(CSR_ESCAPE_LIMIT, 32'h7FFF_FFFF);
            end
            1: begin
               csr_write(CSR_SHIFT_X, 32'h8000_0000);  csr_write(CSR_SHIFT_Y, 32'h7FFF_FFFF);
               csr_write(CSR_ZOOM_SCALE, 32'h8000_0000);
               csr_write(CSR_ESCAPE_LIMIT, 0);
            end
            2: load_defaults();
            default: begin
               csr_write(CSR_BEND_A_X, $urandom_range(536870911) - 268435456);
               csr_write(CSR_BEND_A_Y, $urandom_range(536870911) - 268435456);
               csr_write(CSR_BEND_B_X, $urandom_range(536870911) - 268435456);
               csr_write(CSR_BEND_B_Y, $urandom_range(536870911) - 268435456);
               csr_write(CSR_SHIFT_X, $urandom_range(134217727) - 67108864);
               csr_write(CSR_SHIFT_Y, $urandom_range(134217727) - 67108864);
               csr_write(CSR_ZOOM_SCALE, $urandom_range(805306367) - 402653184);
               csr_write(CSR_ESCAPE_LIMIT, $urandom_range(32'h7FFF_FFFF));
            end
         endcase
         send_many(10);
         drain();
      end
      load_defaults();
   endtask

   // receiver holds off while the sender keeps offering
   task automatic test_backpressure();
      idle_mode = IDLE_NONE;
      hold_until = cycle_no + 3000;
      send_many(6);
      drain();
   endtask

   // under both idles, the sender stops until every count is back, then resumes
   task automatic test_pause_resume();
      idle_mode = IDLE_BOTH;
      send_many(4);
      drain();
      send_many(4);
      drain();
   endtask

   // ---------------- receiver, checker, watchdog ----------------

   always @(negedge clock) begin
      if (cycle_no < hold_until) rsp_tready <= 1'b0;
      else if (idle_mode == IDLE_RECV) rsp_tready <= $urandom_range(99) >= 74;
      else if (idle_mode == IDLE_BOTH) rsp_tready <= $urandom_range(99) >= 7;
      else rsp_tready <= 1'b1;
   end

   // compare each result transaction with the oldest expected count
   always @(posedge clock) begin
      cycle_no <= cycle_no + 1;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (count_q.size() == 0) begin
            $display("%0t: unexpected result, expected none, actual leaf_count %0d",
                     $time, rsp_tdata[17:0]);
            errors++;
         end else begin
            if (rsp_tdata[17:0] != count_q[0][17:0]) begin
               $display("%0t: leaf_count mismatch, expected %0d, actual %0d",
                        $time, count_q[0], rsp_tdata[17:0]);
               errors++;
            end
            void'(count_q.pop_front());
         end
      end
   end

   // count cycles with no transaction on either channel
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCH_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // ---------------- sequence ----------------

   initial begin
      bend_x[0] = BEND_A_X_RST; bend_y[0] = BEND_A_Y_RST;
      bend_x[1] = BEND_B_X_RST; bend_y[1] = BEND_B_Y_RST;
      shift_x = SHIFT_X_RST; shift_y = SHIFT_Y_RST; zoom = ZOOM_RST;
      limit_q56 = longint'(LIMIT_RST) << QBITS;
      repeat (4) @(negedge clock);
      reset <= 1'b0;
      test_directed();
      test_config_sweep();
      test_backpressure();
      test_pause_resume();
      @(negedge clock);
      req_tvalid <= 1'b0;
      drain();
      if (errors == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

// ===== mobius_pair_escape_leaf_count.f =====
+incdir+rtl/core
rtl/core/mpe_pkg.sv
rtl/core/mpe_map_unit.sv
rtl/core/mobius_pair_escape_leaf_count.sv
rtl/core/mpe_checker.sv
bench/tb_mobius_pair_escape_leaf_count.sv
